FILE: src/stit_pkg.sv
// ----------------------------------------------------------------------------
// stit_pkg
// Shared widths, types and codes for the strip to indexed triangle converter.
// ----------------------------------------------------------------------------
package stit_pkg;

    // Grid and store geometry
    localparam int GRID_SIDE   = 65;
    localparam int GRID_LIM    = GRID_SIDE - 1;
    localparam int STORE_DEPTH = GRID_SIDE * GRID_SIDE;
    localparam int KEY_W       = $clog2(STORE_DEPTH);
    localparam int COORD_W     = $clog2(GRID_SIDE);
    localparam int IN_COORD_W  = 7;
    localparam int CMP_W       = (IN_COORD_W > COORD_W) ? IN_COORD_W : COORD_W;

    // Field widths
    localparam int POS_W      = 48;
    localparam int CELL_W     = 40;
    localparam int HEIGHT_W   = 32;
    localparam int VNUM_W     = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 48;

    // Position arithmetic: product of a coordinate and a cell size, then the
    // origin added or subtracted with room for the carry
    localparam int PROD_W = COORD_W + CELL_W;
    localparam int SUM_W  = ((POS_W > PROD_W + 1) ? POS_W : PROD_W + 1) + 1;

    // Queue and output buffer depths (powers of two)
    localparam int Q_DEPTH    = 4;
    localparam int Q_PTR_W    = $clog2(Q_DEPTH);
    localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);
    localparam int OUT_DEPTH  = 4;
    localparam int OUT_PTR_W  = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W  = $clog2(OUT_DEPTH + 1);

    // Item function codes
    localparam logic FUNC_VERTEX = 1'b0;
    localparam logic FUNC_CLEAR  = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_WEST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_NORTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CELL_WIDTH   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CELL_HEIGHT  = 2'd3;

    // Reference slots within one triangle
    localparam logic [1:0] REF_FIRST  = 2'd0;
    localparam logic [1:0] REF_SECOND = 2'd1;
    localparam logic [1:0] REF_THIRD  = 2'd2;

    // Classified strip item, front to back
    typedef struct packed {
        logic                       clear;
        logic [KEY_W-1:0]           key;
        logic signed [POS_W-1:0]    east;
        logic signed [POS_W-1:0]    north;
        logic signed [HEIGHT_W-1:0] height;
    } vtx_t;

    // One vertex reference on its way to the map lookup
    typedef struct packed {
        logic [KEY_W-1:0]           key;
        logic signed [POS_W-1:0]    east;
        logic signed [POS_W-1:0]    north;
        logic signed [HEIGHT_W-1:0] height;
        logic                       last;
    } ref_t;

    // One result item
    typedef struct packed {
        logic [VNUM_W-1:0]          number;
        logic                       is_new;
        logic signed [POS_W-1:0]    east;
        logic signed [POS_W-1:0]    north;
        logic signed [HEIGHT_W-1:0] height;
        logic                       last;
    } out_t;

    // Vertex map entry
    typedef struct packed {
        logic              valid;
        logic [VNUM_W-1:0] number;
    } map_t;

    // Clamp a widened position into the signed 48-bit range
    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [SUM_W-1:0] v);
        logic fits;
        logic signed [POS_W-1:0] r;
        fits = (v[SUM_W-1:POS_W-1] == '0) || (v[SUM_W-1:POS_W-1] == '1);
        if (fits)
            r = v[POS_W-1:0];
        else if (v[SUM_W-1])
            r = {1'b1, {(POS_W-1){1'b0}}};
        else
            r = {1'b0, {(POS_W-1){1'b1}}};
        return r;
    endfunction

endpackage

FILE: src/stit_front.sv
// ----------------------------------------------------------------------------
// stit_front
// Input stage: holds the configuration, clamps the grid coordinates, forms
// the store key and the world position of each strip vertex.
// ----------------------------------------------------------------------------
module stit_front
    import stit_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_write,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic                       func,
    input  logic [IN_COORD_W-1:0]      grid_col,
    input  logic [IN_COORD_W-1:0]      grid_row,
    input  logic signed [HEIGHT_W-1:0] sample_height,
    input  logic                       sweeping,
    input  logic                       q_full,
    output logic                       q_push,
    output vtx_t                       q_data
);

    // Configuration registers
    logic signed [POS_W-1:0] origin_west_reg, origin_west_next;
    logic signed [POS_W-1:0] origin_north_reg, origin_north_next;
    logic [CELL_W-1:0]       cell_width_reg, cell_width_next;
    logic [CELL_W-1:0]       cell_height_reg, cell_height_next;

    // Input stage registers
    logic                       f1_valid_reg, f1_valid_next;
    logic                       f1_clear_reg;
    logic [KEY_W-1:0]           f1_key_reg;
    logic [PROD_W-1:0]          f1_east_prod_reg;
    logic [PROD_W-1:0]          f1_north_prod_reg;
    logic signed [POS_W-1:0]    f1_west_reg;
    logic signed [POS_W-1:0]    f1_north_reg;
    logic signed [HEIGHT_W-1:0] f1_height_reg;

    logic                       accept;
    logic [CMP_W-1:0]           col_wide;
    logic [CMP_W-1:0]           row_wide;
    logic [COORD_W-1:0]         col_sat;
    logic [COORD_W-1:0]         row_sat;
    logic [KEY_W-1:0]           key;
    logic signed [SUM_W-1:0]    east_sum;
    logic signed [SUM_W-1:0]    north_sum;

    // Decode configuration writes
    always_comb
    begin
        origin_west_next  = origin_west_reg;
        origin_north_next = origin_north_reg;
        cell_width_next   = cell_width_reg;
        cell_height_next  = cell_height_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                REG_ORIGIN_WEST:  origin_west_next  = cfg_data[POS_W-1:0];
                REG_ORIGIN_NORTH: origin_north_next = cfg_data[POS_W-1:0];
                REG_CELL_WIDTH:   cell_width_next   = cfg_data[CELL_W-1:0];
                REG_CELL_HEIGHT:  cell_height_next  = cfg_data[CELL_W-1:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_west_reg  <= '0;
            origin_north_reg <= '0;
            cell_width_reg   <= '0;
            cell_height_reg  <= '0;
        end
        else
        begin
            origin_west_reg  <= origin_west_next;
            origin_north_reg <= origin_north_next;
            cell_width_reg   <= cell_width_next;
            cell_height_reg  <= cell_height_next;
        end
    end

    // Hold input while the stage cannot drain or the map is being cleared
    assign in_stall = sweeping || (f1_valid_reg && q_full);
    assign accept   = in_valid && !in_stall;
    assign q_push   = f1_valid_reg && !q_full;

    // Clamp coordinates to the grid and form the store key
    always_comb
    begin
        col_wide = CMP_W'(grid_col);
        row_wide = CMP_W'(grid_row);
        if (col_wide > CMP_W'(GRID_LIM))
            col_wide = CMP_W'(GRID_LIM);
        if (row_wide > CMP_W'(GRID_LIM))
            row_wide = CMP_W'(GRID_LIM);
        col_sat = col_wide[COORD_W-1:0];
        row_sat = row_wide[COORD_W-1:0];
        key     = KEY_W'(row_sat) * KEY_W'(GRID_SIDE) + KEY_W'(col_sat);
    end

    always_comb
    begin
        f1_valid_next = f1_valid_reg;
        if (accept)
            f1_valid_next = 1'b1;
        else if (q_push)
            f1_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            f1_valid_reg <= 1'b0;
        else
            f1_valid_reg <= f1_valid_next;
    end

    // Capture the item, its scaled offsets and the origins in force
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            f1_clear_reg      <= (func == FUNC_CLEAR);
            f1_key_reg        <= key;
            f1_east_prod_reg  <= PROD_W'(col_sat) * PROD_W'(cell_width_reg);
            f1_north_prod_reg <= PROD_W'(row_sat) * PROD_W'(cell_height_reg);
            f1_west_reg       <= origin_west_reg;
            f1_north_reg      <= origin_north_reg;
            f1_height_reg     <= sample_height;
        end
    end

    // Add the origins and clamp to the position range
    always_comb
    begin
        east_sum  = SUM_W'(f1_west_reg) + SUM_W'($signed({1'b0, f1_east_prod_reg}));
        north_sum = SUM_W'(f1_north_reg) - SUM_W'($signed({1'b0, f1_north_prod_reg}));
        q_data.clear  = f1_clear_reg;
        q_data.key    = f1_key_reg;
        q_data.east   = sat_pos(east_sum);
        q_data.north  = sat_pos(north_sum);
        q_data.height = f1_height_reg;
    end

endmodule

FILE: src/stit_queue.sv
// ----------------------------------------------------------------------------
// stit_queue
// Short FIFO of classified strip items between the front and the back.
// ----------------------------------------------------------------------------
module stit_queue
    import stit_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  vtx_t push_data,
    output logic full,
    input  logic pop,
    output logic head_valid,
    output vtx_t head_data
);

    vtx_t               entries [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = entries[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store pushed items
    always_ff @(posedge clk)
    begin
        if (push)
            entries[wr_ptr_reg] <= push_data;
    end

endmodule

FILE: src/stit_back.sv
// ----------------------------------------------------------------------------
// stit_back
// Strip sequencer, vertex map lookup and output buffer. Keeps the two
// pending vertices and the winding parity, issues three references per
// triangle and numbers each new grid vertex.
// ----------------------------------------------------------------------------
module stit_back
    import stit_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       q_valid,
    input  vtx_t                       q_data,
    output logic                       q_pop,
    output logic                       sweeping,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [VNUM_W-1:0]          vertex_number,
    output logic                       is_new,
    output logic signed [POS_W-1:0]    world_east,
    output logic signed [POS_W-1:0]    world_north,
    output logic signed [HEIGHT_W-1:0] vertex_height,
    output logic                       last
);

    typedef enum logic [1:0] {
        ST_RUN   = 2'b01,
        ST_SWEEP = 2'b10
    } bk_state_t;

    bk_state_t          state_reg, state_next;
    logic [KEY_W-1:0]   sweep_addr_reg, sweep_addr_next;
    logic [1:0]         phase_reg, phase_next;
    logic [1:0]         pend_cnt_reg, pend_cnt_next;
    logic               odd_reg, odd_next;
    logic [VNUM_W-1:0]  vcount_reg, vcount_next;
    vtx_t               pend0_reg, pend0_next;
    vtx_t               pend1_reg, pend1_next;

    // Lookup stage
    logic               r_valid_reg;
    ref_t               r_ref_reg;
    map_t               map_rd_reg;
    logic               fwd_valid_reg;
    logic [KEY_W-1:0]   fwd_key_reg;
    logic [VNUM_W-1:0]  fwd_num_reg;

    // Vertex map
    map_t               map_mem [STORE_DEPTH];
    logic               mem_we;
    logic [KEY_W-1:0]   mem_wa;
    map_t               mem_wd;

    // Output buffer
    out_t                 obuf [OUT_DEPTH];
    logic [OUT_PTR_W-1:0] o_wr_ptr_reg;
    logic [OUT_PTR_W-1:0] o_rd_ptr_reg;
    logic [OUT_CNT_W-1:0] o_cnt_reg, o_cnt_next;
    logic                 o_pop;

    logic               issue;
    ref_t               issue_ref;
    logic               new_odd;
    logic               can_issue;
    vtx_t               pick;
    logic               fwd_hit;
    logic               hit;
    logic [VNUM_W-1:0]  hit_num;
    out_t               result;

    assign sweeping  = (state_reg == ST_SWEEP);
    assign new_odd   = !odd_reg;
    assign can_issue = (OUT_CNT_W'(o_cnt_reg) + OUT_CNT_W'(r_valid_reg))
                       < OUT_CNT_W'(OUT_DEPTH);

    // Resolve the reference in the lookup stage, forwarding the previous one
    always_comb
    begin
        fwd_hit = fwd_valid_reg && (fwd_key_reg == r_ref_reg.key);
        hit     = fwd_hit || map_rd_reg.valid;
        hit_num = fwd_hit ? fwd_num_reg : map_rd_reg.number;
        result.last = r_ref_reg.last;
        if (hit)
        begin
            result.number = hit_num;
            result.is_new = 1'b0;
            result.east   = '0;
            result.north  = '0;
            result.height = '0;
        end
        else
        begin
            result.number = vcount_reg;
            result.is_new = 1'b1;
            result.east   = r_ref_reg.east;
            result.north  = r_ref_reg.north;
            result.height = r_ref_reg.height;
        end
    end

    // Sequence strip items, clears and the map sweep
    always_comb
    begin
        state_next      = state_reg;
        sweep_addr_next = sweep_addr_reg;
        phase_next      = phase_reg;
        pend_cnt_next   = pend_cnt_reg;
        odd_next        = odd_reg;
        vcount_next     = vcount_reg;
        pend0_next      = pend0_reg;
        pend1_next      = pend1_reg;
        q_pop           = 1'b0;
        issue           = 1'b0;
        mem_we          = 1'b0;
        mem_wa          = sweep_addr_reg;
        mem_wd          = '0;
        pick            = q_data;

        case (phase_reg)
            REF_FIRST:  pick = new_odd ? pend0_reg : pend1_reg;
            REF_SECOND: pick = new_odd ? pend1_reg : pend0_reg;
            default:    pick = q_data;
        endcase
        issue_ref.key    = pick.key;
        issue_ref.east   = pick.east;
        issue_ref.north  = pick.north;
        issue_ref.height = pick.height;
        issue_ref.last   = (phase_reg == REF_THIRD);

        case (state_reg)
            ST_SWEEP:
            begin
                mem_we = 1'b1;
                if (sweep_addr_reg == KEY_W'(STORE_DEPTH - 1))
                    state_next = ST_RUN;
                else
                    sweep_addr_next = sweep_addr_reg + 1'b1;
            end
            ST_RUN:
            begin
                if (q_valid)
                begin
                    if (q_data.clear)
                    begin
                        // Wait for the lookup stage to drain, then sweep
                        if (!r_valid_reg)
                        begin
                            q_pop           = 1'b1;
                            state_next      = ST_SWEEP;
                            sweep_addr_next = '0;
                            pend_cnt_next   = '0;
                            odd_next        = 1'b0;
                            vcount_next     = '0;
                            phase_next      = REF_FIRST;
                        end
                    end
                    else if (pend_cnt_reg < 2'd2)
                    begin
                        q_pop = 1'b1;
                        if (pend_cnt_reg == 2'd0)
                            pend0_next = q_data;
                        else
                            pend1_next = q_data;
                        pend_cnt_next = pend_cnt_reg + 1'b1;
                    end
                    else if (can_issue)
                    begin
                        issue = 1'b1;
                        if (phase_reg == REF_THIRD)
                        begin
                            q_pop      = 1'b1;
                            phase_next = REF_FIRST;
                            odd_next   = new_odd;
                            pend0_next = pend1_reg;
                            pend1_next = q_data;
                        end
                        else
                        begin
                            phase_next = phase_reg + 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                state_next      = ST_SWEEP;
                sweep_addr_next = '0;
            end
        endcase

        // Append a new vertex on a map miss
        if (r_valid_reg && !hit)
        begin
            mem_we       = 1'b1;
            mem_wa       = r_ref_reg.key;
            mem_wd.valid = 1'b1;
            mem_wd.number = vcount_reg;
            vcount_next  = vcount_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_SWEEP;
            sweep_addr_reg <= '0;
            phase_reg      <= REF_FIRST;
            pend_cnt_reg   <= '0;
            odd_reg        <= 1'b0;
            vcount_reg     <= '0;
            r_valid_reg    <= 1'b0;
            fwd_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            sweep_addr_reg <= sweep_addr_next;
            phase_reg      <= phase_next;
            pend_cnt_reg   <= pend_cnt_next;
            odd_reg        <= odd_next;
            vcount_reg     <= vcount_next;
            r_valid_reg    <= issue;
            fwd_valid_reg  <= r_valid_reg;
        end
    end

    // Hold pending vertices, the issued reference and the forward copy
    always_ff @(posedge clk)
    begin
        pend0_reg <= pend0_next;
        pend1_reg <= pend1_next;
        if (issue)
            r_ref_reg <= issue_ref;
        if (r_valid_reg)
        begin
            fwd_key_reg <= r_ref_reg.key;
            fwd_num_reg <= result.number;
        end
    end

    // Vertex map: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            map_mem[mem_wa] <= mem_wd;
        if (issue)
            map_rd_reg <= map_mem[issue_ref.key];
    end

    // Output buffer
    assign o_pop     = out_valid && !out_stall;
    assign out_valid = (o_cnt_reg != '0);

    always_comb
    begin
        o_cnt_next = o_cnt_reg;
        if (r_valid_reg && !o_pop)
            o_cnt_next = o_cnt_reg + 1'b1;
        else if (o_pop && !r_valid_reg)
            o_cnt_next = o_cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_wr_ptr_reg <= '0;
            o_rd_ptr_reg <= '0;
            o_cnt_reg    <= '0;
        end
        else
        begin
            if (r_valid_reg)
                o_wr_ptr_reg <= o_wr_ptr_reg + 1'b1;
            if (o_pop)
                o_rd_ptr_reg <= o_rd_ptr_reg + 1'b1;
            o_cnt_reg <= o_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (r_valid_reg)
            obuf[o_wr_ptr_reg] <= result;
    end

    // Drive the result ports from the buffer head
    always_comb
    begin
        vertex_number = obuf[o_rd_ptr_reg].number;
        is_new        = obuf[o_rd_ptr_reg].is_new;
        world_east    = obuf[o_rd_ptr_reg].east;
        world_north   = obuf[o_rd_ptr_reg].north;
        vertex_height = obuf[o_rd_ptr_reg].height;
        last          = obuf[o_rd_ptr_reg].last;
    end

endmodule

FILE: src/strip_to_indexed_triangles.sv
// ----------------------------------------------------------------------------
// strip_to_indexed_triangles
// Turns a triangle strip of grid vertices into an indexed triangle list,
// numbering each grid vertex once and giving its world position.
//
//   Channel  Handshake             Payload
//   in       in_valid / in_stall   func, grid_col, grid_row, sample_height
//   out      out_valid / out_stall vertex_number, is_new, world_east,
//                                  world_north, vertex_height, last
//   cfg      cfg_write             cfg_index, cfg_data
//
// A vertex that completes a triangle issues three references, one map read
// each on the single read port of the vertex map. A vertex that only turns
// pending needs no map read; a clear sweeps all 4225 map entries. After
// reset the same sweep runs with in_stall high. A result passes the input
// stage register, item queue, lookup stage and output buffer; out_stall
// backs up through a four-entry output buffer and a four-entry item queue.
// ----------------------------------------------------------------------------
module strip_to_indexed_triangles
    import stit_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_write,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic                       func,
    input  logic [IN_COORD_W-1:0]      grid_col,
    input  logic [IN_COORD_W-1:0]      grid_row,
    input  logic signed [HEIGHT_W-1:0] sample_height,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [VNUM_W-1:0]          vertex_number,
    output logic                       is_new,
    output logic signed [POS_W-1:0]    world_east,
    output logic signed [POS_W-1:0]    world_north,
    output logic signed [HEIGHT_W-1:0] vertex_height,
    output logic                       last
);

    logic sweeping;
    logic q_full;
    logic q_push;
    vtx_t q_push_data;
    logic q_pop;
    logic q_valid;
    vtx_t q_head;

    // Classify and position incoming items
    stit_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .func          (func),
        .grid_col      (grid_col),
        .grid_row      (grid_row),
        .sample_height (sample_height),
        .sweeping      (sweeping),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_data        (q_push_data)
    );

    // Decouple front and back
    stit_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_data  (q_push_data),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_data  (q_head)
    );

    // Emit references and number vertices
    stit_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_data        (q_head),
        .q_pop         (q_pop),
        .sweeping      (sweeping),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .vertex_number (vertex_number),
        .is_new        (is_new),
        .world_east    (world_east),
        .world_north   (world_north),
        .vertex_height (vertex_height),
        .last          (last)
    );

endmodule
